@@ sv/ir_range_linearizer_defines.svh @@
// assertion helpers shared by the range linearizer rtl
`ifndef IR_RANGE_LINEARIZER_DEFINES_SVH
`define IR_RANGE_LINEARIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IRL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irl assertion failed");

// next-cycle implication, disabled while in reset
`define IRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irl assertion failed");

`endif

@@ sv/irl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irl_pkg
// Calibration table, reciprocal table and shared types of the range linearizer.
// ----------------------------------------------------------------------------
package irl_pkg;

  localparam int BREAKPOINT_COUNT = 13;
  localparam int TABLE_SLOTS      = 32;
  localparam int POINT_N = (BREAKPOINT_COUNT > TABLE_SLOTS) ? TABLE_SLOTS :
                           (BREAKPOINT_COUNT < 2) ? 2 : BREAKPOINT_COUNT;

  localparam int MV_W    = 13;
  localparam int DIST_W  = 8;
  localparam int SEG_W   = $clog2(TABLE_SLOTS);
  localparam int MAG_W   = MV_W + DIST_W;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int CFG_INDEX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FAR_DISTANCE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_DISTANCE = 2'd1;

  localparam logic [DIST_W-1:0] FAR_RESET  = 8'd140;
  localparam logic [DIST_W-1:0] NEAR_RESET = 8'd10;

  // breakpoints, voltage rising and distance falling; unused slots hold zero
  localparam logic [MV_W-1:0] CAL_MV [TABLE_SLOTS] = '{
    0: 13'd33,   1: 13'd157,  2: 13'd338,  3: 13'd561,  4: 13'd656,
    5: 13'd768,  6: 13'd824,  7: 13'd968,  8: 13'd1181, 9: 13'd1460,
    10: 13'd1883, 11: 13'd2452, 12: 13'd2653, default: 13'd0
  };
  localparam logic [DIST_W-1:0] CAL_DIST [TABLE_SLOTS] = '{
    0: 8'd130, 1: 8'd120, 2: 8'd110, 3: 8'd100, 4: 8'd90,
    5: 8'd80,  6: 8'd70,  7: 8'd60,  8: 8'd50,  9: 8'd40,
    10: 8'd30, 11: 8'd20, 12: 8'd12, default: 8'd0
  };

  // segment width in mV, kept at one or more for empty slots
  function automatic int seg_den(int i);
    int d;
    d = int'(CAL_MV[i+1]) - int'(CAL_MV[i]);
    return (d < 1) ? 1 : d;
  endfunction

  localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;

  // floor(2^24 / segment width), one entry per segment
  localparam logic [RECIP_W-1:0] RECIP [TABLE_SLOTS-1] = '{
    RECIP_W'(RECIP_ONE / seg_den(0)),  RECIP_W'(RECIP_ONE / seg_den(1)),
    RECIP_W'(RECIP_ONE / seg_den(2)),  RECIP_W'(RECIP_ONE / seg_den(3)),
    RECIP_W'(RECIP_ONE / seg_den(4)),  RECIP_W'(RECIP_ONE / seg_den(5)),
    RECIP_W'(RECIP_ONE / seg_den(6)),  RECIP_W'(RECIP_ONE / seg_den(7)),
    RECIP_W'(RECIP_ONE / seg_den(8)),  RECIP_W'(RECIP_ONE / seg_den(9)),
    RECIP_W'(RECIP_ONE / seg_den(10)), RECIP_W'(RECIP_ONE / seg_den(11)),
    RECIP_W'(RECIP_ONE / seg_den(12)), RECIP_W'(RECIP_ONE / seg_den(13)),
    RECIP_W'(RECIP_ONE / seg_den(14)), RECIP_W'(RECIP_ONE / seg_den(15)),
    RECIP_W'(RECIP_ONE / seg_den(16)), RECIP_W'(RECIP_ONE / seg_den(17)),
    RECIP_W'(RECIP_ONE / seg_den(18)), RECIP_W'(RECIP_ONE / seg_den(19)),
    RECIP_W'(RECIP_ONE / seg_den(20)), RECIP_W'(RECIP_ONE / seg_den(21)),
    RECIP_W'(RECIP_ONE / seg_den(22)), RECIP_W'(RECIP_ONE / seg_den(23)),
    RECIP_W'(RECIP_ONE / seg_den(24)), RECIP_W'(RECIP_ONE / seg_den(25)),
    RECIP_W'(RECIP_ONE / seg_den(26)), RECIP_W'(RECIP_ONE / seg_den(27)),
    RECIP_W'(RECIP_ONE / seg_den(28)), RECIP_W'(RECIP_ONE / seg_den(29)),
    RECIP_W'(RECIP_ONE / seg_den(30))
  };

  typedef enum logic [1:0] {
    SEL_INTERP,
    SEL_FAR,
    SEL_NEAR
  } sel_t;

  // everything one item carries down the pipe
  typedef struct packed {
    sel_t              sel;
    logic [SEG_W-1:0]  seg;
    logic [MV_W-1:0]   mv;
    logic [MV_W-1:0]   off;
    logic [MV_W-1:0]   den;
    logic              dneg;
    logic [DIST_W-1:0] ddmag;
    logic [MAG_W-1:0]  mag;
    logic [DIST_W-1:0] qe;
    logic [MAG_W-1:0]  rem;
    logic [DIST_W:0]   fl;
    logic              nz;
  } pipe_t;

endpackage

@@ sv/ir_range_linearizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_linearizer
// Infrared range sensor reading to distance by piecewise-linear interpolation.
// ----------------------------------------------------------------------------
// A reading in mV enters on the input channel and its distance in cm leaves
// on the output; one reading is taken every cycle unless stalled. The path is a
// seven-register pipeline: segment search, table lookup, offset times
// distance step, multiply by the segment's reciprocal, remainder, quotient
// correction, and the output register with saturation and the far/near
// selection. Each stage holds its item only while the one after it is full
// and stalled, so bubbles close up under back-pressure. Readings below the
// first breakpoint report far_distance, readings at or above the last report
// near_distance, both with out_of_table set. Configuration writes complete in
// the cycle they are offered and should only be made while the pipe is empty.
`include "ir_range_linearizer_defines.svh"

module ir_range_linearizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [irl_pkg::MV_W-1:0]             millivolts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [irl_pkg::DIST_W-1:0]           distance_cm,
  output logic                                 out_of_table,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [irl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [irl_pkg::DIST_W-1:0]           cfg_data
);

  localparam int NSTAGE = 6;

  logic [irl_pkg::DIST_W-1:0] far_distance;
  logic [irl_pkg::DIST_W-1:0] near_distance;

  irl_pkg::pipe_t st  [NSTAGE];
  irl_pkg::pipe_t nxt [NSTAGE];
  logic [NSTAGE-1:0] stage_valid;
  logic [NSTAGE:0]   load;

  logic [irl_pkg::DIST_W-1:0] distance_next;
  logic                       out_of_table_next;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_distance  <= irl_pkg::FAR_RESET;
      near_distance <= irl_pkg::NEAR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        irl_pkg::REG_FAR_DISTANCE:  far_distance  <= cfg_data;
        irl_pkg::REG_NEAR_DISTANCE: near_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    load[NSTAGE] = !out_valid || out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      load[k] = !stage_valid[k] || load[k+1];
    end
  end
  assign in_ready = load[0];

  always_comb begin
    logic found;
    logic [irl_pkg::SEG_W-1:0]  seg_hi;
    logic [irl_pkg::MV_W:0]     den_full;
    logic [irl_pkg::DIST_W:0]   dd;
    logic [irl_pkg::PROD_W-1:0] prod;

    found    = 1'b0;
    seg_hi   = '0;
    den_full = '0;
    dd       = '0;
    prod     = '0;

    // stage 0: segment search
    nxt[0]     = '0;
    nxt[0].mv  = millivolts;
    for (int c = 0; c < irl_pkg::TABLE_SLOTS - 1; c++) begin
      if (c < irl_pkg::POINT_N - 1 && !found && millivolts >= irl_pkg::CAL_MV[c] &&
          millivolts < irl_pkg::CAL_MV[c+1]) begin
        found      = 1'b1;
        nxt[0].seg = irl_pkg::SEG_W'(c);
      end
    end
    if (millivolts >= irl_pkg::CAL_MV[irl_pkg::POINT_N-1]) begin
      nxt[0].sel = irl_pkg::SEL_NEAR;
    end else if (millivolts >= irl_pkg::CAL_MV[0] && found) begin
      nxt[0].sel = irl_pkg::SEL_INTERP;
    end else begin
      nxt[0].sel = irl_pkg::SEL_FAR;
    end

    // stage 1: breakpoint lookup
    nxt[1]      = st[0];
    seg_hi      = st[0].seg + 1'b1;
    nxt[1].off  = st[0].mv - irl_pkg::CAL_MV[st[0].seg];
    den_full    = {1'b0, irl_pkg::CAL_MV[seg_hi]} - {1'b0, irl_pkg::CAL_MV[st[0].seg]};
    nxt[1].den  = den_full[irl_pkg::MV_W-1:0];
    dd          = {1'b0, irl_pkg::CAL_DIST[st[0].seg]} - {1'b0, irl_pkg::CAL_DIST[seg_hi]};
    nxt[1].dneg = dd[irl_pkg::DIST_W];
    nxt[1].ddmag = dd[irl_pkg::DIST_W] ? irl_pkg::DIST_W'(-dd) : dd[irl_pkg::DIST_W-1:0];

    // stage 2: numerator magnitude
    nxt[2]     = st[1];
    nxt[2].mag = irl_pkg::MAG_W'(st[1].off) * irl_pkg::MAG_W'(st[1].ddmag);

    // stage 3: quotient estimate, floor or one below
    nxt[3]    = st[2];
    prod      = irl_pkg::PROD_W'(st[2].mag) * irl_pkg::PROD_W'(irl_pkg::RECIP[st[2].seg]);
    nxt[3].qe = prod[irl_pkg::RECIP_SHIFT +: irl_pkg::DIST_W];

    // stage 4: remainder of the estimate
    nxt[4]     = st[3];
    nxt[4].rem = st[3].mag - irl_pkg::MAG_W'(st[3].qe) * irl_pkg::MAG_W'(st[3].den);

    // stage 5: correct the estimate by one where needed
    nxt[5] = st[4];
    if (st[4].rem >= irl_pkg::MAG_W'(st[4].den)) begin
      nxt[5].fl  = {1'b0, st[4].qe} + 1'b1;
      nxt[5].rem = st[4].rem - irl_pkg::MAG_W'(st[4].den);
    end else begin
      nxt[5].fl  = {1'b0, st[4].qe};
    end
    nxt[5].nz = (nxt[5].rem != '0);
  end

  // output stage: step, saturation and out-of-table selection
  always_comb begin
    logic signed [irl_pkg::DIST_W+2:0] base;
    logic signed [irl_pkg::DIST_W+2:0] val;
    base = $signed({3'b000, irl_pkg::CAL_DIST[st[5].seg]});
    if (st[5].dneg) begin
      val = base + $signed({2'b00, st[5].fl});
    end else begin
      val = base - $signed({2'b00, st[5].fl}) - $signed({10'd0, st[5].nz});
    end
    out_of_table_next = 1'b1;
    case (st[5].sel)
      irl_pkg::SEL_INTERP: begin
        out_of_table_next = 1'b0;
        if (val < 0) begin
          distance_next = '0;
        end else if (val > 255) begin
          distance_next = '1;
        end else begin
          distance_next = val[irl_pkg::DIST_W-1:0];
        end
      end
      irl_pkg::SEL_NEAR: distance_next = near_distance;
      default:           distance_next = far_distance;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (load[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
      if (load[NSTAGE]) begin
        out_valid <= stage_valid[NSTAGE-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (load[k]) begin
        st[k] <= nxt[k];
      end
    end
    if (load[NSTAGE]) begin
      distance_cm  <= distance_next;
      out_of_table <= out_of_table_next;
    end
  end

  // an empty first stage always takes a transfer
  `IRL_ASSERT(a_ready_when_empty, !stage_valid[0], in_ready)
  // interpolation only ever sees an offset inside its segment
  `IRL_ASSERT(a_offset_in_segment, stage_valid[1] && st[1].sel == irl_pkg::SEL_INTERP,
              st[1].off < st[1].den)
  // the reciprocal estimate is at most one below the true quotient
  `IRL_ASSERT(a_estimate_close, stage_valid[4] && st[4].sel == irl_pkg::SEL_INTERP,
              st[4].rem < (irl_pkg::MAG_W'(st[4].den) << 1))
  // an interpolated item never leaves flagged as out of table
  `IRL_ASSERT_NEXT(a_interp_flag, stage_valid[5] && load[NSTAGE] &&
                   st[5].sel == irl_pkg::SEL_INTERP, !out_of_table)

endmodule

@@ dv/ir_range_linearizer_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_linearizer_chk
// Watches the channels of the range linearizer and checks every distance.
// ----------------------------------------------------------------------------
// Keeps its own copy of the far/near registers from the configuration
// transfers, works out the distance of each accepted reading from the
// calibration breakpoints and compares every output transfer, in order,
// against the oldest distance still owed.
module ir_range_linearizer_chk
  import irl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [MV_W-1:0]        millivolts,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [DIST_W-1:0]      distance_cm,
  input  logic                   out_of_table,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]      cfg_data,
  output int                     mismatches,
  output int                     pending
);

  typedef struct {
    logic [MV_W-1:0]   mv;
    logic [DIST_W-1:0] dist_cm;
    logic              oot;
  } range_t;

  range_t            owed_ranges[$];
  logic [DIST_W-1:0] far_cm;
  logic [DIST_W-1:0] near_cm;

  function automatic range_t linearize(logic [MV_W-1:0] mv);
    range_t r;
    bit     hit;
    int     num;
    int     den;
    int     step;
    int     v;
    r.mv      = mv;
    r.dist_cm = far_cm;
    r.oot     = 1'b1;
    hit       = 1'b0;
    if (mv >= CAL_MV[POINT_N-1]) begin
      r.dist_cm = near_cm;
    end else if (mv >= CAL_MV[0]) begin
      for (int c = 0; c < POINT_N - 1; c++) begin
        if (!hit && mv >= CAL_MV[c] && mv < CAL_MV[c+1]) begin
          hit = 1'b1;
          den = int'(CAL_MV[c+1]) - int'(CAL_MV[c]);
          num = (int'(mv) - int'(CAL_MV[c])) * (int'(CAL_DIST[c]) - int'(CAL_DIST[c+1]));
          // round the step up so the distance is truncated toward zero
          if (num >= 0) step = (num + den - 1) / den;
          else step = -((-num) / den);
          v = int'(CAL_DIST[c]) - step;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          r.dist_cm = DIST_W'(v);
          r.oot     = 1'b0;
        end
      end
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
    far_cm     = FAR_RESET;
    near_cm    = NEAR_RESET;
  end

  always @(posedge clk) begin
    range_t want;
    if (rst) begin
      owed_ranges.delete();
      far_cm  = FAR_RESET;
      near_cm = NEAR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FAR_DISTANCE: far_cm = cfg_data;
          REG_NEAR_DISTANCE: near_cm = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_ranges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected output transfer dist %0d oot %0b",
                     $realtime, distance_cm, out_of_table);
        end else begin
          want = owed_ranges.pop_front();
          if (distance_cm !== want.dist_cm || out_of_table !== want.oot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mv %0d expected dist %0d oot %0b, got dist %0d oot %0b",
                       $realtime, want.mv, want.dist_cm, want.oot, distance_cm,
                       out_of_table);
          end
        end
      end
      if (in_valid && in_ready)
        owed_ranges.push_back(linearize(millivolts));
    end
    pending = owed_ranges.size();
  end

endmodule

@@ dv/ir_range_linearizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_linearizer_tb
// Stimulus and verdict for the infrared range linearizer.
// ----------------------------------------------------------------------------
// Sweeps every calibration breakpoint and its neighbour, then runs random
// readings biased into the calibrated span under several far/near settings,
// with random gaps on the input side and random stalls on the output side.
// The checker beside the block predicts and compares every distance.
module ir_range_linearizer_tb;
  import irl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MV_MAX      = (1 << MV_W) - 1;

  // indexes with no register behind them, writes must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [MV_W-1:0]        millivolts;
  logic                   out_valid;
  logic                   out_ready;
  logic [DIST_W-1:0]      distance_cm;
  logic                   out_of_table;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIST_W-1:0]      cfg_data;
  int                     mismatches;
  int                     pending;

  int gap_pct;
  int stall_pct;
  int stall_left;
  int cycle_count;

  ir_range_linearizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .millivolts   (millivolts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_cm  (distance_cm),
    .out_of_table (out_of_table),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ir_range_linearizer_chk u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .millivolts   (millivolts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_cm  (distance_cm),
    .out_of_table (out_of_table),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver stalls, mostly short with the odd long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                                                  $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [MV_W-1:0] pick_reading();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 70) return MV_W'($urandom_range(CAL_MV[0], CAL_MV[POINT_N-1] - 1));
    if (r < 78) return MV_W'($urandom_range(0, CAL_MV[0] - 1));
    if (r < 88) begin
      // hug a breakpoint from either side
      k = $urandom_range(0, POINT_N - 1);
      return MV_W'(int'(CAL_MV[k]) + $urandom_range(0, 2) - 1);
    end
    return MV_W'($urandom_range(0, MV_MAX));
  endfunction

  // called and returns at a falling edge; leaves in_valid high
  task automatic send_reading(logic [MV_W-1:0] mv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    millivolts <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [DIST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_distances(logic [DIST_W-1:0] far_cm, logic [DIST_W-1:0] near_cm,
                               bit spare);
    wait_idle();
    write_register(REG_FAR_DISTANCE, far_cm);
    if (spare) write_register(REG_SPARE_A, 8'($urandom_range(0, 255)));
    write_register(REG_NEAR_DISTANCE, near_cm);
    if (spare) write_register(REG_SPARE_B, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  task automatic breakpoint_sweep();
    send_reading('0);
    for (int k = 0; k < POINT_N; k++) begin
      send_reading(CAL_MV[k] - 1'b1);
      send_reading(CAL_MV[k]);
    end
    send_reading(MV_W'(MV_MAX));
  endtask

  task automatic random_readings(int count, int gaps, int stalls);
    gap_pct   = gaps;
    stall_pct = stalls;
    repeat (count) send_reading(pick_reading());
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    millivolts = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gap_pct    = 20;
    stall_pct  = 20;
    stall_left = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers still at their reset values
    breakpoint_sweep();
    set_distances(8'd0, 8'd255, 1'b1);
    breakpoint_sweep();
    random_readings(220, 0, 0);
    set_distances(8'd255, 8'd0, 1'b1);
    random_readings(260, 60, 60);
    set_distances(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
    random_readings(300, 25, 25);
    set_distances(8'h55, 8'hAA, 1'b0);
    random_readings(250, 10, 40);
    set_distances(FAR_RESET, NEAR_RESET, 1'b0);
    random_readings(250, 40, 10);

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("ir_range_linearizer_tb: PASS");
    end else begin
      $display("ir_range_linearizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("%0t: run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
    $display("ir_range_linearizer_tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/irl_pkg.sv
sv/ir_range_linearizer.sv
dv/ir_range_linearizer_chk.sv
dv/ir_range_linearizer_tb.sv
